// File: rtl/core/mbrle_pkg.sv
// Shared types, constants and control store for the metablock RLE decoder.
// Used by mbrle_seq, mbrle_dp and metablock_bitstream_rle_decoder_core.
package mbrle_pkg;

    localparam int BLOCK_ENTRIES_DEF = 256;

    // Left-aligned bit buffer: up to 13 pending bits plus one new byte.
    localparam int BUF_W  = 21;
    localparam int CNT_W  = 5;
    localparam int RUN_W  = 6;
    localparam int STEP_W = 2;

    localparam logic [1:0] CODE_RUN  = 2'd2;
    localparam logic [1:0] CODE_INCR = 2'd3;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_DECODE,
        OP_EMIT,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LOADED,
        C_SHORT,
        C_BLOCK_DONE,
        C_EMIT_BUSY
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              jmp;
        logic [STEP_W-1:0]  target;
        t_cond              hold;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic loaded;
        logic short_cmd;
        logic block_done;
        logic emit_busy;
    } t_status;

    localparam logic [STEP_W-1:0] ST_WAIT   = 2'd0;
    localparam logic [STEP_W-1:0] ST_DECODE = 2'd1;
    localparam logic [STEP_W-1:0] ST_EMIT   = 2'd2;
    localparam logic [STEP_W-1:0] ST_LOOP   = 2'd3;

    // Control store. Priority per step: jump, then hold, then fall through.
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            ST_WAIT:   w = '{op: OP_WAIT,   jmp: C_NEVER,      target: ST_WAIT,
                             hold: C_NOT_LOADED};
            ST_DECODE: w = '{op: OP_DECODE, jmp: C_SHORT,      target: ST_WAIT,
                             hold: C_NEVER};
            ST_EMIT:   w = '{op: OP_EMIT,   jmp: C_BLOCK_DONE, target: ST_WAIT,
                             hold: C_EMIT_BUSY};
            ST_LOOP:   w = '{op: OP_NOP,    jmp: C_ALWAYS,     target: ST_DECODE,
                             hold: C_NEVER};
            default:   w = '{op: OP_NOP,    jmp: C_ALWAYS,     target: ST_WAIT,
                             hold: C_NEVER};
        endcase
        return w;
    endfunction

    // Bits a command needs, including its 2-bit code
    function automatic logic [CNT_W-1:0] cmd_need(input logic [1:0] code);
        logic [CNT_W-1:0] n;
        unique case (code)
            CODE_RUN:  n = CNT_W'(14);
            CODE_INCR: n = CNT_W'(2);
            default:   n = CNT_W'(8);
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/mbrle_seq.sv
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on mbrle_pkg.
module mbrle_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbrle_pkg::t_status i_status,
    output mbrle_pkg::t_op     o_op
);

    logic [mbrle_pkg::STEP_W-1:0] r_step;
    logic [mbrle_pkg::STEP_W-1:0] n_step;
    mbrle_pkg::t_uword            uw;
    logic                         jmp_take;
    logic                         hold_take;

    function automatic logic cond_eval(input mbrle_pkg::t_cond c,
                                       input mbrle_pkg::t_status s);
        logic r;
        unique case (c)
            mbrle_pkg::C_NEVER:      r = 1'b0;
            mbrle_pkg::C_ALWAYS:     r = 1'b1;
            mbrle_pkg::C_NOT_LOADED: r = !s.loaded;
            mbrle_pkg::C_SHORT:      r = s.short_cmd;
            mbrle_pkg::C_BLOCK_DONE: r = s.block_done;
            mbrle_pkg::C_EMIT_BUSY:  r = s.emit_busy;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        uw        = mbrle_pkg::uc_rom(r_step);
        jmp_take  = cond_eval(uw.jmp, i_status);
        hold_take = cond_eval(uw.hold, i_status);
        if (jmp_take) begin
            n_step = uw.target;
        end else if (hold_take) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
        o_op = uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mbrle_pkg::ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: rtl/core/mbrle_dp.sv
// Datapath: bit buffer, command field extraction, run counter, output register.
// Driven by the op from mbrle_seq; depends on mbrle_pkg.
module mbrle_dp #(
    parameter int BLOCK_ENTRIES = mbrle_pkg::BLOCK_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbrle_pkg::t_op     i_op,
    output mbrle_pkg::t_status o_status,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic               i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast,
    output logic               o_m_tuser
);

    localparam int CW = $clog2(BLOCK_ENTRIES + 1);

    logic [mbrle_pkg::BUF_W-1:0] r_buf, n_buf;
    logic [mbrle_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [mbrle_pkg::RUN_W-1:0] r_run, n_run;
    logic [7:0]                  r_prev, n_prev;
    logic [CW-1:0]               r_emit, n_emit;
    logic                        r_fin, n_fin;
    logic                        r_ovalid, n_ovalid;
    logic [7:0]                  r_odata, n_odata;
    logic                        r_olast, n_olast;
    logic                        r_oitem, n_oitem;

    logic                        accept;
    logic                        fin_eff;
    logic [mbrle_pkg::BUF_W-1:0] buf_eff;
    logic [mbrle_pkg::CNT_W-1:0] cnt_eff;
    logic [mbrle_pkg::BUF_W-1:0] ins;
    logic [1:0]                  code;
    logic [mbrle_pkg::CNT_W-1:0] need;
    logic                        short_cmd;
    logic                        fire;
    logic [CW-1:0]               emit_inc;
    logic                        last_blk;

    assign o_s_tready = (i_op == mbrle_pkg::OP_WAIT);
    assign accept     = i_s_tvalid && o_s_tready;
    assign fin_eff    = i_s_tuser ? 1'b0 : r_fin;
    assign buf_eff    = i_s_tuser ? '0 : r_buf;
    assign cnt_eff    = i_s_tuser ? '0 : r_cnt;
    // new byte goes right behind the pending bits
    assign ins        = {i_s_tdata, (mbrle_pkg::BUF_W - 8)'(0)} >> cnt_eff;

    assign code      = r_buf[mbrle_pkg::BUF_W-1 -: 2];
    assign need      = mbrle_pkg::cmd_need(code);
    assign short_cmd = (r_cnt < need);

    assign fire     = !r_ovalid || i_m_tready;
    assign emit_inc = r_emit + 1'b1;
    assign last_blk = (emit_inc == CW'(BLOCK_ENTRIES));

    always_comb begin
        n_buf    = r_buf;
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_prev   = r_prev;
        n_emit   = r_emit;
        n_fin    = r_fin;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_oitem  = r_oitem;
        n_ovalid = r_ovalid && !i_m_tready;

        o_status            = '0;
        o_status.short_cmd  = short_cmd;
        o_status.emit_busy  = 1'b1;

        unique case (i_op)
            mbrle_pkg::OP_WAIT: begin
                if (accept) begin
                    if (i_s_tuser) begin
                        n_prev = '0;
                        n_emit = '0;
                        n_fin  = 1'b0;
                    end
                    if (!fin_eff) begin
                        o_status.loaded = 1'b1;
                        n_buf = buf_eff | ins;
                        n_cnt = cnt_eff + mbrle_pkg::CNT_W'(8);
                    end
                end
            end
            mbrle_pkg::OP_DECODE: begin
                if (!short_cmd) begin
                    n_buf = r_buf << need;
                    n_cnt = r_cnt - need;
                    n_run = mbrle_pkg::RUN_W'(1);
                    case (code)
                        mbrle_pkg::CODE_RUN: begin
                            n_run  = mbrle_pkg::RUN_W'(r_buf[18:14]) +
                                     mbrle_pkg::RUN_W'(2);
                            n_prev = {1'b0, r_buf[13:7]};
                        end
                        mbrle_pkg::CODE_INCR: begin
                            n_prev = r_prev + 8'd1;
                        end
                        default: begin
                            n_prev = r_buf[mbrle_pkg::BUF_W-1 -: 8];
                        end
                    endcase
                end
            end
            mbrle_pkg::OP_EMIT: begin
                if (fire) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_prev;
                    n_olast  = last_blk;
                    // bits left after this command are already in the buffer,
                    // so whether another command follows is known now
                    n_oitem  = last_blk ||
                               (r_run == mbrle_pkg::RUN_W'(1) && short_cmd);
                    n_emit   = emit_inc;
                    n_run    = r_run - 1'b1;
                    o_status.emit_busy = (r_run != mbrle_pkg::RUN_W'(1));
                    if (last_blk) begin
                        o_status.block_done = 1'b1;
                        n_fin = 1'b1;
                        n_buf = '0;
                        n_cnt = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf    <= '0;
            r_cnt    <= '0;
            r_prev   <= '0;
            r_emit   <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_buf    <= n_buf;
            r_cnt    <= n_cnt;
            r_prev   <= n_prev;
            r_emit   <= n_emit;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_oitem <= n_oitem;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oitem;

endmodule

// File: rtl/core/metablock_bitstream_rle_decoder_core.sv
// Metablock bitstream RLE decoder, top level.
// A byte is taken in the wait step; each complete command then passes through
// the decode step, the emit step (which puts out the bytes of its run, holds under
// output backpressure and returns to wait when the block ends) and the loop step;
// a final decode step finds the command incomplete; only then is a new byte taken.
// Reset (i_rst_n low, synchronous) clears the decoder as at the start of a block.
module metablock_bitstream_rle_decoder_core #(
    parameter int BLOCK_ENTRIES = mbrle_pkg::BLOCK_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tuser,   // [0] block_start
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] tile_value
    output logic       o_m_tlast,   // block_last
    output logic       o_m_tuser    // [0] item_last
);

    mbrle_pkg::t_op     op;
    mbrle_pkg::t_status status;

    mbrle_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    mbrle_dp #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .o_status   (status),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
